// File: rtl/ttvp_pkg.sv
package ttvp_pkg;

    // Default number format
    localparam int FRAC_DIGITS_DEF = 7;
    localparam int VALUE_WIDTH_DEF = 48;

    // Powers of ten up to 10^9 fit in 34 bits
    localparam int POW_W  = 34;
    localparam int FD_W   = 4;
    localparam int CHAR_W = 8;
    localparam int FID_W  = 3;
    localparam int NUM_TAGS = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    // Tags, first character in the top byte
    localparam logic [31:0] TAG_TABLE [NUM_TAGS] = '{
        32'h4C61743A,   // Lat:
        32'h4C6E673A,   // Lng:
        32'h546D703A,   // Tmp:
        32'h5072733A,   // Prs:
        32'h48756D3A,   // Hum:
        32'h5861633A,   // Xac:
        32'h5961633A,   // Yac:
        32'h5A61633A    // Zac:
    };

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_TAG,
        MODE_VALUE,
        MODE_SKIP
    } mode_t;

    typedef enum logic [1:0] {
        PH_BEFORE_SIGN,
        PH_INTEGER,
        PH_FRACTION,
        PH_DONE
    } phase_t;

    // Control from the parser sequencer to the number unit
    typedef struct packed {
        logic clear;
        logic feed;
    } num_cmd_t;

    function automatic logic [POW_W-1:0] pow10(input logic [FD_W-1:0] n);
        logic [POW_W-1:0] p;
        begin
            case (n)
                4'd0:    p = 34'd1;
                4'd1:    p = 34'd10;
                4'd2:    p = 34'd100;
                4'd3:    p = 34'd1000;
                4'd4:    p = 34'd10000;
                4'd5:    p = 34'd100000;
                4'd6:    p = 34'd1000000;
                4'd7:    p = 34'd10000000;
                4'd8:    p = 34'd100000000;
                4'd9:    p = 34'd1000000000;
                default: p = 34'd1;
            endcase
            return p;
        end
    endfunction

endpackage

// File: rtl/telemetry_tag_value_parser.sv
// Channel | Handshake             | Payload
// input   | in_valid / in_ready   | char_in
// result  | out_valid / out_ready | field_id, value, bad_tag, message_end
//
// One character per cycle unless a held result is not taken: input register, one
// pass of tag compare and multiply-by-ten accumulate, then the result register.
// A character passes the input register, then the result register, before its result shows.
// in_ready drops only while a held result is not taken and a character waits.
// Reset (rst_n low, asynchronous) returns the parser to scanning for '$'.
module telemetry_tag_value_parser
    import ttvp_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [CHAR_W-1:0]             char_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [FID_W-1:0]              field_id,
    output logic signed [VALUE_WIDTH-1:0] value,
    output logic                          bad_tag,
    output logic                          message_end
);

    // Input stage
    logic              stage_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              stage_go;
    logic              fire;

    // Parser state
    mode_t             mode_reg, mode_next;
    logic [23:0]       tag_reg, tag_next;
    logic [1:0]        tcnt_reg, tcnt_next;
    logic [FID_W-1:0]  fid_reg, fid_next;

    // Result register
    logic                   out_valid_reg;
    logic [FID_W-1:0]       fid_out_reg;
    logic [VALUE_WIDTH-1:0] value_out_reg;
    logic                   bad_out_reg;
    logic                   end_out_reg;

    logic                   emit;
    logic [FID_W-1:0]       emit_fid;
    logic [VALUE_WIDTH-1:0] emit_value;
    logic                   emit_bad;
    logic                   emit_end;

    logic                   tag_hit;
    logic [FID_W-1:0]       tag_idx;
    num_cmd_t               num_cmd;
    logic [VALUE_WIDTH-1:0] num_value;

    // Stage moves when the result register is free or being drained
    assign stage_go = !out_valid_reg || out_ready;
    assign fire     = stage_valid_reg && stage_go;
    assign in_ready = !stage_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_go)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_in;
        end
    end

    ttvp_tag_match u_tag_match (
        .tag_chars (tag_reg),
        .last_char (char_reg),
        .hit       (tag_hit),
        .idx       (tag_idx)
    );

    ttvp_num_unit #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_num_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (num_cmd),
        .ch        (char_reg),
        .value_out (num_value)
    );

    // Parser sequencer: next state and result
    always_comb
    begin
        mode_next     = mode_reg;
        tag_next      = tag_reg;
        tcnt_next     = tcnt_reg;
        fid_next      = fid_reg;
        num_cmd.clear = 1'b0;
        num_cmd.feed  = 1'b0;
        emit          = 1'b0;
        emit_fid      = '0;
        emit_value    = '0;
        emit_bad      = 1'b0;
        emit_end      = 1'b0;
        if (fire)
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (char_reg == CH_DOLLAR)
                    begin
                        mode_next = MODE_TAG;
                        tag_next  = '0;
                        tcnt_next = '0;
                    end
                end
                MODE_TAG:
                begin
                    if (char_reg == CH_NUL)
                    begin
                        mode_next = MODE_IDLE;
                        tcnt_next = '0;
                        emit      = 1'b1;
                        emit_bad  = 1'b1;
                        emit_end  = 1'b1;
                    end
                    else if (tcnt_reg != 2'd3)
                    begin
                        tag_next  = {tag_reg[15:0], char_reg};
                        tcnt_next = tcnt_reg + 2'd1;
                    end
                    else if (tag_hit)
                    begin
                        mode_next     = MODE_VALUE;
                        fid_next      = tag_idx;
                        tcnt_next     = '0;
                        num_cmd.clear = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_SKIP;
                        tcnt_next = '0;
                        emit      = 1'b1;
                        emit_bad  = 1'b1;
                    end
                end
                MODE_VALUE:
                begin
                    if (char_reg == CH_NUL || char_reg == CH_NL)
                    begin
                        mode_next     = MODE_IDLE;
                        num_cmd.clear = 1'b1;
                        emit          = 1'b1;
                        emit_fid      = fid_reg;
                        emit_value    = num_value;
                        emit_end      = (char_reg == CH_NUL);
                    end
                    else
                    begin
                        num_cmd.feed = 1'b1;
                    end
                end
                MODE_SKIP:
                begin
                    if (char_reg == CH_NUL)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            tag_reg  <= '0;
            tcnt_reg <= '0;
            fid_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            tag_reg  <= tag_next;
            tcnt_reg <= tcnt_next;
            fid_reg  <= fid_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go)
        begin
            out_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            fid_out_reg   <= emit_fid;
            value_out_reg <= emit_value;
            bad_out_reg   <= emit_bad;
            end_out_reg   <= emit_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_id    = fid_out_reg;
    assign value       = value_out_reg;
    assign bad_tag     = bad_out_reg;
    assign message_end = end_out_reg;

endmodule

// File: rtl/ttvp_tag_match.sv
module ttvp_tag_match
    import ttvp_pkg::*;
(
    input  logic [23:0]       tag_chars,
    input  logic [CHAR_W-1:0] last_char,
    output logic              hit,
    output logic [FID_W-1:0]  idx
);

    logic [31:0] word;

    assign word = {tag_chars, last_char};

    // Compare against every tag; lowest index wins
    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        for (int i = NUM_TAGS - 1; i >= 0; i--)
        begin
            if (word == TAG_TABLE[i])
            begin
                hit = 1'b1;
                idx = FID_W'(i);
            end
        end
    end

endmodule

// File: rtl/ttvp_num_unit.sv
module ttvp_num_unit
    import ttvp_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  num_cmd_t               cmd,
    input  logic [CHAR_W-1:0]      ch,
    output logic [VALUE_WIDTH-1:0] value_out
);

    localparam int EW  = VALUE_WIDTH + 5;
    localparam int PW  = POW_W + FD_W;
    localparam logic [FD_W-1:0] FD_MAX = FD_W'(FRAC_DIGITS);
    localparam logic [VALUE_WIDTH-1:0] CAP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Scaled magnitude: min(digits * 10^(FRAC_DIGITS - fraction digits), CAP)
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [FD_W-1:0]        fd_reg, fd_next;
    phase_t                 phase_reg, phase_next;
    logic                   neg_reg, neg_next;

    logic                   is_digit, is_ws, is_sign;
    logic [FD_W-1:0]        digit;
    logic [FD_W-1:0]        pow_idx;
    logic [PW-1:0]          int_add, frac_add;
    logic [EW-1:0]          mag_ext, int_sum, frac_sum;
    logic [VALUE_WIDTH-1:0] int_sat, frac_sat;

    // Character classes
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = FD_W'(ch - CH_ZERO);
    assign is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) ||
                      (ch == CH_FF) || (ch == CH_CR);
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

    // Integer digit: mag*10 + d*10^F, saturated
    assign mag_ext = EW'(mag_reg);
    assign int_add = {{POW_W{1'b0}}, digit} * {{FD_W{1'b0}}, pow10(FD_MAX)};
    assign int_sum = (mag_ext << 3) + (mag_ext << 1) + EW'(int_add);
    assign int_sat = (int_sum > EW'(CAP)) ? CAP : int_sum[VALUE_WIDTH-1:0];

    // Fraction digit: mag + d*10^(F-fd-1), saturated
    assign pow_idx  = FD_MAX - fd_reg - FD_W'(1);
    assign frac_add = {{POW_W{1'b0}}, digit} * {{FD_W{1'b0}}, pow10(pow_idx)};
    assign frac_sum = mag_ext + EW'(frac_add);
    assign frac_sat = (frac_sum > EW'(CAP)) ? CAP : frac_sum[VALUE_WIDTH-1:0];

    // Next state of the number
    always_comb
    begin
        mag_next   = mag_reg;
        fd_next    = fd_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        if (cmd.clear)
        begin
            mag_next   = '0;
            fd_next    = '0;
            phase_next = PH_BEFORE_SIGN;
            neg_next   = 1'b0;
        end
        else if (cmd.feed)
        begin
            unique case (phase_reg)
                PH_BEFORE_SIGN, PH_INTEGER:
                begin
                    if (phase_reg == PH_BEFORE_SIGN && is_ws)
                    begin
                        phase_next = PH_BEFORE_SIGN;
                    end
                    else if (phase_reg == PH_BEFORE_SIGN && is_sign)
                    begin
                        neg_next   = (ch == CH_MINUS);
                        phase_next = PH_INTEGER;
                    end
                    else if (is_digit)
                    begin
                        mag_next   = int_sat;
                        phase_next = PH_INTEGER;
                    end
                    else if (ch == CH_DOT)
                    begin
                        phase_next = PH_FRACTION;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_FRACTION:
                begin
                    if (is_digit)
                    begin
                        // digits past the last kept place are dropped
                        if (fd_reg < FD_MAX)
                        begin
                            mag_next = frac_sat;
                            fd_next  = fd_reg + FD_W'(1);
                        end
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg   <= '0;
            fd_reg    <= '0;
            phase_reg <= PH_BEFORE_SIGN;
            neg_reg   <= 1'b0;
        end
        else
        begin
            mag_reg   <= mag_next;
            fd_reg    <= fd_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
        end
    end

    // Signed result; positive side clips one below CAP
    always_comb
    begin
        if (neg_reg)
        begin
            value_out = ~mag_reg + VALUE_WIDTH'(1);
        end
        else if (mag_reg == CAP)
        begin
            value_out = CAP - VALUE_WIDTH'(1);
        end
        else
        begin
            value_out = mag_reg;
        end
    end

endmodule

// File: rtl/ttvp_checker.sv
module ttvp_checker
    import ttvp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [FID_W-1:0]              field_id,
    input logic signed [VALUE_WIDTH-1:0] value,
    input logic                          bad_tag,
    input logic                          message_end
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(field_id) &&
            $stable(value) && $stable(bad_tag) && $stable(message_end))
        else $error("result changed while stalled");

    // A tag error carries a zero index and value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_tag |-> field_id == '0 && value == '0)
        else $error("tag error with nonzero payload");

    // Input stalls only behind a result that is not taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // A fresh result follows an item accepted through the input register
    a_result_lat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching item");

endmodule

bind telemetry_tag_value_parser ttvp_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ttvp_checker (.*);
